/* hdl/sfpa_pkg.sv */
// Shared constants for the segregated-fit page allocator.
package sfpa_pkg;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOFIT    = 2'd1;
    localparam logic [1:0] ST_MISALIGN = 2'd2;
    localparam logic [1:0] ST_NOTUSED  = 2'd3;

    localparam logic [1:0] CFG_SHIFT = 2'd0;
    localparam logic [1:0] CFG_MAX   = 2'd1;
    localparam logic [1:0] CFG_TOTAL = 2'd2;

    localparam int unsigned MAX_SHIFT = 20;

endpackage

/* hdl/segregated_fit_page_allocator.sv */
// Top level of the segregated-fit page allocator: free lists, sequencer and counters.
//
//  channel | signals                                    | direction
//  --------+--------------------------------------------+----------
//  in      | i_valid, o_stall, i_mode, i_size_bytes,    | in
//          | i_free_offset                              |
//  out     | o_valid, i_stall, o_status, o_block_offset,| out
//          | o_alloc_total, o_free_total                |
//  cfg     | i_cfg_we, i_cfg_index, i_cfg_data          | in
//
// An allocation visits class lists and checks their list nodes in turn, and pushes
// a split-off remainder back onto a free list; a rejected size goes to the result.
// A free reads the block, then reads its upper neighbor and merges it while it is free
// and the sum fits the maximum block size; a rejected offset goes to the result.
// Every result is loaded into the output register.
// After reset and after every configuration write, a clearing pass over NUM_PAGES pages
// is followed by laying out the blocks; the input is stalled meanwhile.
// A result waits in the output register while the next item is already accepted.
module segregated_fit_page_allocator
    import sfpa_pkg::*;
#(
    parameter int NUM_PAGES   = 1024,
    parameter int NUM_CLASSES = 11
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_mode,
    input  logic [31:0] i_size_bytes,
    input  logic [31:0] i_free_offset,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [31:0] o_block_offset,
    output logic [31:0] o_alloc_total,
    output logic [31:0] o_free_total,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [10:0] i_cfg_data
);

    localparam int PW = $clog2(NUM_PAGES + 1);
    localparam int AW = $clog2(NUM_PAGES);
    localparam int CW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam logic [PW-1:0] NONE    = PW'(NUM_PAGES);
    localparam logic [31:0]   PG_LIM  = 32'(NUM_PAGES);
    localparam logic [31:0]   CLS_LIM = 32'((64'd1 << NUM_CLASSES) - 64'd1);

    typedef enum logic [3:0] {
        S_CLR, S_BLD, S_IDLE, S_A_HEAD, S_A_RD, S_A_CHK, S_UNL, S_A_SET,
        S_PUSH_A, S_PUSH_B, S_F_RD, S_F_CHK, S_M_ADDR, S_M_CHK, S_DONE
    } t_state;

    typedef enum logic [1:0] {
        OP_BLD, OP_ALLOC, OP_FREE
    } t_op;

    t_state          r_state;
    t_op             r_op;
    logic [4:0]      r_shift;
    logic [10:0]     r_maxr, r_totr;
    logic [PW-1:0]   r_head [NUM_CLASSES];
    logic [PW-1:0]   r_ptr, r_q, r_pages, r_usz, r_bs, r_pp, r_pr, r_nx, r_oh;
    logic [PW:0]     r_nxp;
    logic [CW-1:0]   r_cls, r_last;
    logic            r_whole;
    logic [31:0]     r_acnt, r_fcnt;
    logic            r_ov;
    logic [1:0]      r_st;
    logic [31:0]     r_boff;
    logic [1:0]      r_out_status;
    logic [31:0]     r_out_boff, r_out_atot, r_out_ftot;

    // State memories, each single port with registered read.
    logic [PW-1:0] m_size [NUM_PAGES];
    logic          m_used [NUM_PAGES];
    logic [PW-1:0] m_next [NUM_PAGES];
    logic [PW-1:0] m_prev [NUM_PAGES];
    logic [PW-1:0] rd_size, rd_next, rd_prev;
    logic          rd_used;

    logic          w_size_en, w_used_en, w_next_en, w_prev_en;
    logic [AW-1:0] a_size, a_used, a_next, a_prev;
    logic [PW-1:0] d_size, d_next, d_prev;
    logic          d_used;

    always_ff @(posedge i_clk) begin
        if (w_size_en) m_size[a_size] <= d_size;
        rd_size <= m_size[a_size];
        if (w_used_en) m_used[a_used] <= d_used;
        rd_used <= m_used[a_used];
        if (w_next_en) m_next[a_next] <= d_next;
        rd_next <= m_next[a_next];
        if (w_prev_en) m_prev[a_prev] <= d_prev;
        rd_prev <= m_prev[a_prev];
    end

    function automatic logic [CW-1:0] class_of(input logic [PW-1:0] s);
        int c;
        c = 0;
        for (int b = 1; b < PW; b++) begin
            if (s[b]) c = b;
        end
        if (c > NUM_CLASSES - 1) c = NUM_CLASSES - 1;
        return CW'(c);
    endfunction

    // Effective configuration.
    logic [31:0] w_mx32;
    always_comb begin
        w_mx32 = 32'(r_maxr);
        if (w_mx32 == 32'd0) w_mx32 = 32'd1;
        if (w_mx32 > PG_LIM) w_mx32 = PG_LIM;
        if (w_mx32 > CLS_LIM) w_mx32 = CLS_LIM;
    end
    logic [31:0]   w_tot32;
    logic [PW-1:0] w_mx, w_tot;
    logic [4:0]    w_sh;
    assign w_tot32 = (32'(r_totr) > PG_LIM) ? PG_LIM : 32'(r_totr);
    assign w_mx    = w_mx32[PW-1:0];
    assign w_tot   = w_tot32[PW-1:0];
    assign w_sh    = (r_shift > 5'(MAX_SHIFT)) ? 5'(MAX_SHIFT) : r_shift;

    // Page count of an allocation request.
    logic [32:0]   w_pg33;
    logic [31:0]   w_lowmask;
    logic [PW-1:0] w_pages;
    logic          w_pow2;
    assign w_lowmask = (32'd1 << w_sh) - 32'd1;
    assign w_pg33    = (33'(i_size_bytes) + 33'(w_lowmask)) >> w_sh;
    assign w_pages   = w_pg33[PW-1:0];
    assign w_pow2    = (w_pages & (w_pages - PW'(1))) == '0;

    // Layout step, split and merge arithmetic.
    logic [PW-1:0] w_rem, w_bld_n;
    logic [PW:0]   w_rpos, w_msum;
    logic          w_split;
    logic [CW-1:0] w_push_cls;
    assign w_rem      = w_tot - r_ptr;
    assign w_bld_n    = (w_rem > w_mx) ? w_mx : w_rem;
    assign w_rpos     = {1'b0, r_q} + {1'b0, r_pages};
    assign w_split    = !r_whole && (r_usz > r_pages) && (w_rpos < (PW+1)'(NUM_PAGES));
    assign w_msum     = {1'b0, r_bs} + {1'b0, rd_size};
    assign w_push_cls = class_of(r_bs);

    logic w_accept, w_cfg, w_load;
    assign w_accept = i_valid && (r_state == S_IDLE);
    assign o_stall  = (r_state != S_IDLE);
    assign w_cfg    = i_cfg_we && (i_cfg_index == CFG_SHIFT || i_cfg_index == CFG_MAX ||
                                   i_cfg_index == CFG_TOTAL);
    assign w_load   = (r_state == S_DONE) && (!r_ov || !i_stall) && !w_cfg;

    always_comb begin
        w_size_en = 1'b0;
        w_used_en = 1'b0;
        w_next_en = 1'b0;
        w_prev_en = 1'b0;
        a_size = r_ptr[AW-1:0];
        a_used = r_ptr[AW-1:0];
        a_next = r_ptr[AW-1:0];
        a_prev = r_ptr[AW-1:0];
        d_size = '0;
        d_used = 1'b0;
        d_next = NONE;
        d_prev = NONE;
        case (r_state)
            S_CLR: begin
                w_size_en = 1'b1;
                w_used_en = 1'b1;
            end
            S_UNL: begin
                if (r_pr != NONE) begin
                    w_next_en = 1'b1; a_next = r_pr[AW-1:0]; d_next = r_nx;
                end
                if (r_nx != NONE) begin
                    w_prev_en = 1'b1; a_prev = r_nx[AW-1:0]; d_prev = r_pr;
                end
                if (r_op == OP_FREE) begin
                    w_size_en = 1'b1; a_size = r_q[AW-1:0]; d_size = '0;
                end
            end
            S_A_SET: begin
                w_used_en = 1'b1; a_used = r_q[AW-1:0]; d_used = 1'b1;
                if (w_split) begin
                    w_size_en = 1'b1; a_size = r_q[AW-1:0]; d_size = r_pages;
                end
            end
            S_PUSH_A: begin
                w_size_en = 1'b1; a_size = r_pp[AW-1:0]; d_size = r_bs;
                w_used_en = 1'b1; a_used = r_pp[AW-1:0]; d_used = 1'b0;
                w_next_en = 1'b1; a_next = r_pp[AW-1:0]; d_next = r_head[w_push_cls];
                w_prev_en = 1'b1; a_prev = r_pp[AW-1:0]; d_prev = NONE;
            end
            S_PUSH_B: begin
                if (r_oh != NONE) begin
                    w_prev_en = 1'b1; a_prev = r_oh[AW-1:0]; d_prev = r_pp;
                end
            end
            S_F_RD: begin
                a_size = r_pp[AW-1:0];
                a_used = r_pp[AW-1:0];
            end
            S_M_ADDR: begin
                a_size = r_nxp[AW-1:0];
                a_used = r_nxp[AW-1:0];
                a_next = r_nxp[AW-1:0];
                a_prev = r_nxp[AW-1:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_op    <= OP_BLD;
            r_shift <= 5'd12;
            r_maxr  <= 11'd64;
            r_totr  <= 11'd1024;
            r_ptr   <= '0;
            r_acnt  <= '0;
            r_fcnt  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_ov <= w_load || (r_ov && i_stall);
            if (w_load) begin
                r_out_status <= r_st;
                r_out_boff   <= r_boff;
                r_out_atot   <= r_acnt;
                r_out_ftot   <= r_fcnt;
            end
            if (w_cfg) begin
                case (i_cfg_index)
                    CFG_SHIFT: r_shift <= i_cfg_data[4:0];
                    CFG_MAX:   r_maxr  <= i_cfg_data;
                    CFG_TOTAL: r_totr  <= i_cfg_data;
                    default:   ;
                endcase
                r_state <= S_CLR;
                r_ptr   <= '0;
            end else begin
                case (r_state)
                    S_CLR: begin
                        if (r_ptr == PW'(NUM_PAGES - 1)) begin
                            r_state <= S_BLD;
                            r_op    <= OP_BLD;
                            r_ptr   <= '0;
                            for (int k = 0; k < NUM_CLASSES; k++) r_head[k] <= NONE;
                        end else begin
                            r_ptr <= r_ptr + PW'(1);
                        end
                    end
                    S_BLD: begin
                        if (r_ptr < w_tot) begin
                            r_pp    <= r_ptr;
                            r_bs    <= w_bld_n;
                            r_ptr   <= r_ptr + w_bld_n;
                            r_state <= S_PUSH_A;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                    S_IDLE: begin
                        if (w_accept) begin
                            r_boff <= '0;
                            if (!i_mode) begin
                                r_op <= OP_ALLOC;
                                if (w_pg33 == 33'd0 || w_pg33 > 33'(w_mx32)) begin
                                    r_st <= ST_NOFIT; r_state <= S_DONE;
                                end else begin
                                    r_pages <= w_pages;
                                    r_cls   <= class_of(w_pages);
                                    r_last  <= class_of(w_mx);
                                    r_whole <= w_pow2;
                                    r_state <= S_A_HEAD;
                                end
                            end else begin
                                r_op <= OP_FREE;
                                if ((i_free_offset & w_lowmask) != 32'd0) begin
                                    r_st <= ST_MISALIGN; r_state <= S_DONE;
                                end else if ((i_free_offset >> w_sh) >= w_tot32) begin
                                    r_st <= ST_NOTUSED; r_state <= S_DONE;
                                end else begin
                                    r_pp    <= PW'(i_free_offset >> w_sh);
                                    r_state <= S_F_RD;
                                end
                            end
                        end
                    end
                    S_A_HEAD: begin
                        if (r_head[r_cls] == NONE) begin
                            r_whole <= 1'b0;
                            if (r_cls == r_last) begin
                                r_st <= ST_NOFIT; r_boff <= '0; r_state <= S_DONE;
                            end else begin
                                r_cls <= r_cls + CW'(1);
                            end
                        end else begin
                            r_ptr   <= r_head[r_cls];
                            r_state <= S_A_RD;
                        end
                    end
                    S_A_RD: r_state <= S_A_CHK;
                    S_A_CHK: begin
                        if (rd_size >= r_pages) begin
                            r_q     <= r_ptr;
                            r_usz   <= rd_size;
                            r_pr    <= rd_prev;
                            r_nx    <= rd_next;
                            r_state <= S_UNL;
                        end else if (rd_next == NONE) begin
                            if (r_cls == r_last) begin
                                r_st <= ST_NOFIT; r_boff <= '0; r_state <= S_DONE;
                            end else begin
                                r_cls <= r_cls + CW'(1); r_state <= S_A_HEAD;
                            end
                        end else begin
                            r_ptr <= rd_next; r_state <= S_A_RD;
                        end
                    end
                    S_UNL: begin
                        if (r_pr == NONE) r_head[class_of(r_usz)] <= r_nx;
                        if (r_op == OP_FREE) begin
                            r_bs    <= r_bs + r_usz;
                            r_nxp   <= r_nxp + {1'b0, r_usz};
                            r_state <= S_M_ADDR;
                        end else begin
                            r_state <= S_A_SET;
                        end
                    end
                    S_A_SET: begin
                        r_acnt <= r_acnt + 32'd1;
                        r_st   <= ST_OK;
                        r_boff <= 32'(r_q) << w_sh;
                        if (w_split) begin
                            r_pp    <= w_rpos[PW-1:0];
                            r_bs    <= r_usz - r_pages;
                            r_state <= S_PUSH_A;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                    S_PUSH_A: begin
                        r_head[w_push_cls] <= r_pp;
                        r_oh    <= r_head[w_push_cls];
                        r_state <= S_PUSH_B;
                    end
                    S_PUSH_B: begin
                        case (r_op)
                            OP_BLD: r_state <= S_BLD;
                            OP_FREE: begin
                                r_fcnt  <= r_fcnt + 32'd1;
                                r_st    <= ST_OK;
                                r_boff  <= '0;
                                r_state <= S_DONE;
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                    S_F_RD: r_state <= S_F_CHK;
                    S_F_CHK: begin
                        if (rd_size == '0 || !rd_used) begin
                            r_st <= ST_NOTUSED; r_state <= S_DONE;
                        end else begin
                            r_bs    <= rd_size;
                            r_nxp   <= {1'b0, r_pp} + {1'b0, rd_size};
                            r_state <= S_M_ADDR;
                        end
                    end
                    S_M_ADDR: begin
                        if (r_nxp >= {1'b0, w_tot}) r_state <= S_PUSH_A;
                        else r_state <= S_M_CHK;
                    end
                    S_M_CHK: begin
                        if (rd_size == '0 || rd_used || w_msum > {1'b0, w_mx}) begin
                            r_state <= S_PUSH_A;
                        end else begin
                            r_q     <= r_nxp[PW-1:0];
                            r_usz   <= rd_size;
                            r_pr    <= rd_prev;
                            r_nx    <= rd_next;
                            r_state <= S_UNL;
                        end
                    end
                    S_DONE: begin
                        if (w_load) r_state <= S_IDLE;
                    end
                    default: r_state <= S_IDLE;
                endcase
            end
        end
    end

    assign o_valid        = r_ov;
    assign o_status       = r_out_status;
    assign o_block_offset = r_out_boff;
    assign o_alloc_total  = r_out_atot;
    assign o_free_total   = r_out_ftot;

endmodule
